// ----- rtl/rzfe_pkg.sv -----
// Shared types, constants and helpers for the zero/0xFF byte run-length encoder.
// Used by rzfe_store, rzfe_seq, rzfe_pack and the top level.
`default_nettype none

package rzfe_pkg;

  // Longest run and largest literal block
  localparam int MAX_BLOCK_LEN = 63;
  localparam int CNT_W         = $clog2(MAX_BLOCK_LEN + 1);
  localparam int ADDR_W        = $clog2(MAX_BLOCK_LEN);

  typedef logic [7:0]        byte_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [ADDR_W-1:0] addr_t;

  localparam cnt_t BLK_MAX = CNT_W'(MAX_BLOCK_LEN);

  // Run code prefixes
  localparam byte_t TAG_ZERO = 8'h40;
  localparam byte_t TAG_ONES = 8'h80;
  localparam byte_t TAG_VAL  = 8'hC0;
  localparam byte_t BYTE_ONES = 8'hFF;
  localparam byte_t BYTE_ZERO = 8'h00;

  // One event from the sequencer to the packer: a byte, or end of the input word's output
  typedef struct packed {
    logic  valid;
    logic  is_end;
    byte_t data;
  } ev_t;

  function automatic logic is_special(input byte_t v);
    return (v == BYTE_ZERO) || (v == BYTE_ONES);
  endfunction

  // Leading byte of a run code
  function automatic byte_t code_byte(input byte_t v, input cnt_t c);
    byte_t cb;
    cb = 8'(c) & 8'h3F;
    if (v == BYTE_ZERO) begin
      return cb | TAG_ZERO;
    end else if (v == BYTE_ONES) begin
      return cb | TAG_ONES;
    end else begin
      return cb | TAG_VAL;
    end
  endfunction

endpackage

`default_nettype wire

// ----- rtl/rle_zero_ff_byte_encoder.sv -----
// Top level of the byte run-length encoder with short codes for 0x00 and 0xFF.
// Depends on rzfe_pkg, rzfe_store, rzfe_seq and rzfe_pack.
//
//   channel | ports                                       | handshake
//   --------+---------------------------------------------+----------------
//   input   | in_data_byte, in_end_of_stream              | in_valid/in_ready
//   result  | out_first_out_byte, out_second_out_byte,    | out_valid/out_ready
//           | out_out_byte_count, out_last_of_run         |
//
// The sequencer takes one input word at a time; in_ready is high only while it is idle.
// Each word passes through control states before its encoded bytes go out; a literal
// block flush sends a count byte plus up to 63 bytes from the store's single read port.
// Reset (rst_n low at a clock edge) empties the run and the literal store; the store
// needs no clearing pass. A stalled result side holds the sequencer byte by byte.
`default_nettype none

module rle_zero_ff_byte_encoder
  import rzfe_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire  [7:0] in_data_byte,
  input  wire        in_end_of_stream,
  output logic       out_valid,
  input  wire        out_ready,
  output logic [7:0] out_first_out_byte,
  output logic [7:0] out_second_out_byte,
  output logic [1:0] out_out_byte_count,
  output logic       out_last_of_run
);

  ev_t   ev;
  logic  ev_ready;
  logic  wr_en;
  addr_t wr_addr;
  byte_t wr_data;
  logic  rd_en;
  addr_t rd_addr;
  byte_t rd_data;

  // Literal store
  rzfe_store u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Run/literal sequencer
  rzfe_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_data_byte),
    .in_eos   (in_end_of_stream),
    .ev       (ev),
    .ev_ready (ev_ready),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  // Byte packer and output register
  rzfe_pack u_pack (
    .clk       (clk),
    .rst_n     (rst_n),
    .ev        (ev),
    .ev_ready  (ev_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_b0    (out_first_out_byte),
    .out_b1    (out_second_out_byte),
    .out_cnt   (out_out_byte_count),
    .out_last  (out_last_of_run)
  );

endmodule

`default_nettype wire

// ----- rtl/rzfe_store.sv -----
// Literal store: one write port, one read port with registered read data.
// Depends on rzfe_pkg.
`default_nettype none

module rzfe_store
  import rzfe_pkg::*;
(
  input  wire   clk,
  input  wire   wr_en,
  input  addr_t wr_addr,
  input  byte_t wr_data,
  input  wire   rd_en,
  input  addr_t rd_addr,
  output byte_t rd_data
);

  byte_t mem [MAX_BLOCK_LEN];
  byte_t rd_data_r;

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ----- rtl/rzfe_seq.sv -----
// Encoder sequencer: closes runs, pushes literals, flushes blocks, emits one byte a cycle while ev_ready is high.
// Depends on rzfe_pkg; drives rzfe_store and feeds rzfe_pack.
`default_nettype none

module rzfe_seq
  import rzfe_pkg::*;
(
  input  wire   clk,
  input  wire   rst_n,
  input  wire   in_valid,
  output logic  in_ready,
  input  byte_t in_byte,
  input  wire   in_eos,
  output ev_t   ev,
  input  wire   ev_ready,
  output logic  wr_en,
  output addr_t wr_addr,
  output byte_t wr_data,
  output logic  rd_en,
  output addr_t rd_addr,
  input  byte_t rd_data
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b000_0000_0001,
    S_CLOSE = 11'b000_0000_0010,
    S_PUSH  = 11'b000_0000_0100,
    S_FLUSH = 11'b000_0000_1000,
    S_FHDR  = 11'b000_0001_0000,
    S_FDATA = 11'b000_0010_0000,
    S_CODE1 = 11'b000_0100_0000,
    S_CODE2 = 11'b000_1000_0000,
    S_AFTER = 11'b001_0000_0000,
    S_TERM  = 11'b010_0000_0000,
    S_ENDS  = 11'b100_0000_0000
  } state_t;

  // Where to go once a literal flush is done
  typedef enum logic [1:0] {
    F_RUN   = 2'd0,
    F_PUSH  = 2'd1,
    F_AFTER = 2'd2,
    F_TERM  = 2'd3
  } fret_t;

  state_t state_r, state_nxt;
  fret_t  fret_r, fret_nxt;
  byte_t  rv_r, rv_nxt;
  cnt_t   rl_r, rl_nxt;
  cnt_t   lc_r, lc_nxt;
  cnt_t   k_r, k_nxt;
  byte_t  byte_r, byte_nxt;
  logic   eos_r, eos_nxt;
  logic   pass_b_r, pass_b_nxt;
  logic   push_two_r, push_two_nxt;
  logic   code_flush_r, code_flush_nxt;
  byte_t  code_val_r, code_val_nxt;
  cnt_t   code_cnt_r, code_cnt_nxt;
  byte_t  lit0_r, lit0_nxt;
  byte_t  lit1_r, lit1_nxt;

  logic   fin_flush;
  logic   fin_code;
  logic   sp;
  cnt_t   rd_idx;

  assign in_ready = (state_r == S_IDLE);
  assign wr_addr  = lc_r[ADDR_W-1:0];
  assign wr_data  = rv_r;
  assign rd_addr  = rd_idx[ADDR_W-1:0];
  assign sp       = is_special(rv_r);

  // Next-state and datapath control
  always_comb begin
    state_nxt      = state_r;
    fret_nxt       = fret_r;
    rv_nxt         = rv_r;
    rl_nxt         = rl_r;
    lc_nxt         = lc_r;
    k_nxt          = k_r;
    byte_nxt       = byte_r;
    eos_nxt        = eos_r;
    pass_b_nxt     = pass_b_r;
    push_two_nxt   = push_two_r;
    code_flush_nxt = code_flush_r;
    code_val_nxt   = code_val_r;
    code_cnt_nxt   = code_cnt_r;
    lit0_nxt       = lit0_r;
    lit1_nxt       = lit1_r;
    ev             = '0;
    wr_en          = 1'b0;
    rd_en          = 1'b0;
    rd_idx         = '0;
    fin_flush      = 1'b0;
    fin_code       = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          byte_nxt = in_byte;
          eos_nxt  = in_eos;
          if ((rl_r != '0) && ((in_byte != rv_r) || (rl_r >= BLK_MAX))) begin
            pass_b_nxt = 1'b0;
            state_nxt  = S_CLOSE;
          end else begin
            if (rl_r == '0) begin
              rv_nxt = in_byte;
              rl_nxt = CNT_W'(1);
            end else begin
              rl_nxt = rl_r + CNT_W'(1);
            end
            pass_b_nxt = 1'b1;
            state_nxt  = in_eos ? S_CLOSE : S_ENDS;
          end
        end
      end

      // Pick run code, literal flush plus run code, or literal push
      S_CLOSE: begin
        code_val_nxt   = rv_r;
        code_cnt_nxt   = rl_r;
        code_flush_nxt = 1'b0;
        if (((rl_r > CNT_W'(1)) && sp) || (rl_r > CNT_W'(2))) begin
          if (lc_r != '0) begin
            fret_nxt  = F_RUN;
            state_nxt = S_FLUSH;
          end else begin
            state_nxt = S_CODE1;
          end
        end else if ((lc_r == '0) && ((rl_r == CNT_W'(2)) || sp)) begin
          state_nxt = S_CODE1;
        end else begin
          push_two_nxt = (rl_r == CNT_W'(2));
          state_nxt    = S_PUSH;
        end
      end

      // Append one literal; flush when the block is full
      S_PUSH: begin
        wr_en        = 1'b1;
        push_two_nxt = 1'b0;
        lc_nxt       = lc_r + CNT_W'(1);
        if (lc_r == '0) begin
          lit0_nxt = rv_r;
        end
        if (lc_r == CNT_W'(1)) begin
          lit1_nxt = rv_r;
        end
        if (lc_r == BLK_MAX - CNT_W'(1)) begin
          fret_nxt  = push_two_r ? F_PUSH : F_AFTER;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = push_two_r ? S_PUSH : S_AFTER;
        end
      end

      // Blocks of one byte, or of two equal bytes, go out as run codes; others get a count byte
      S_FLUSH: begin
        code_flush_nxt = 1'b1;
        code_val_nxt   = lit0_r;
        if (lc_r == CNT_W'(1)) begin
          code_cnt_nxt = CNT_W'(1);
          lc_nxt       = '0;
          state_nxt    = S_CODE1;
        end else if ((lc_r == CNT_W'(2)) && (lit0_r == lit1_r)) begin
          code_cnt_nxt = CNT_W'(2);
          lc_nxt       = '0;
          state_nxt    = S_CODE1;
        end else begin
          state_nxt = S_FHDR;
        end
      end

      // Block count byte; prefetch entry 0
      S_FHDR: begin
        ev.valid = 1'b1;
        ev.data  = 8'(lc_r);
        rd_en    = 1'b1;
        rd_idx   = '0;
        if (ev_ready) begin
          k_nxt     = '0;
          state_nxt = S_FDATA;
        end
      end

      // Block data; read of the next entry overlaps the current byte
      S_FDATA: begin
        ev.valid = 1'b1;
        ev.data  = rd_data;
        rd_idx   = ev_ready ? (k_r + CNT_W'(1)) : k_r;
        rd_en    = (rd_idx < BLK_MAX);
        if (ev_ready) begin
          if (k_r == lc_r - CNT_W'(1)) begin
            lc_nxt    = '0;
            fin_flush = 1'b1;
          end else begin
            k_nxt = k_r + CNT_W'(1);
          end
        end
      end

      S_CODE1: begin
        ev.valid = 1'b1;
        ev.data  = code_byte(code_val_r, code_cnt_r);
        if (ev_ready) begin
          if (is_special(code_val_r)) begin
            fin_code = 1'b1;
          end else begin
            state_nxt = S_CODE2;
          end
        end
      end

      S_CODE2: begin
        ev.valid = 1'b1;
        ev.data  = code_val_r;
        if (ev_ready) begin
          fin_code = 1'b1;
        end
      end

      // Run closed: open the new run, or finish the stream
      S_AFTER: begin
        if (!pass_b_r) begin
          rv_nxt     = byte_r;
          rl_nxt     = CNT_W'(1);
          pass_b_nxt = 1'b1;
          state_nxt  = eos_r ? S_CLOSE : S_ENDS;
        end else if (lc_r != '0) begin
          fret_nxt  = F_TERM;
          state_nxt = S_FLUSH;
        end else begin
          state_nxt = S_TERM;
        end
      end

      // Terminator, then back to reset values
      S_TERM: begin
        ev.valid = 1'b1;
        ev.data  = BYTE_ZERO;
        if (ev_ready) begin
          lc_nxt    = '0;
          rv_nxt    = '0;
          rl_nxt    = '0;
          state_nxt = S_ENDS;
        end
      end

      S_ENDS: begin
        ev.valid  = 1'b1;
        ev.is_end = 1'b1;
        if (ev_ready) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Return from a code or a flush
    if (fin_code && !code_flush_r) begin
      state_nxt = S_AFTER;
    end else if (fin_flush || fin_code) begin
      case (fret_r)
        F_RUN: begin
          code_val_nxt   = rv_r;
          code_cnt_nxt   = rl_r;
          code_flush_nxt = 1'b0;
          state_nxt      = S_CODE1;
        end
        F_PUSH:  state_nxt = S_PUSH;
        F_AFTER: state_nxt = S_AFTER;
        F_TERM:  state_nxt = S_TERM;
        default: state_nxt = S_IDLE;
      endcase
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fret_r       <= F_AFTER;
      rv_r         <= '0;
      rl_r         <= '0;
      lc_r         <= '0;
      k_r          <= '0;
      pass_b_r     <= 1'b0;
      push_two_r   <= 1'b0;
      code_flush_r <= 1'b0;
      eos_r        <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      fret_r       <= fret_nxt;
      rv_r         <= rv_nxt;
      rl_r         <= rl_nxt;
      lc_r         <= lc_nxt;
      k_r          <= k_nxt;
      pass_b_r     <= pass_b_nxt;
      push_two_r   <= push_two_nxt;
      code_flush_r <= code_flush_nxt;
      eos_r        <= eos_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    code_val_r <= code_val_nxt;
    code_cnt_r <= code_cnt_nxt;
    lit0_r     <= lit0_nxt;
    lit1_r     <= lit1_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/rzfe_pack.sv -----
// Packs encoded bytes two to a word and marks the last word of each input word.
// Depends on rzfe_pkg; holds the output register.
`default_nettype none

module rzfe_pack
  import rzfe_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  ev_t        ev,
  output logic       ev_ready,
  output logic       out_valid,
  input  wire        out_ready,
  output byte_t      out_b0,
  output byte_t      out_b1,
  output logic [1:0] out_cnt,
  output logic       out_last
);

  logic [1:0] hold_cnt_r, hold_cnt_nxt;
  byte_t      h0_r, h0_nxt;
  byte_t      h1_r, h1_nxt;
  logic       ov_r, ov_nxt;
  logic       load;
  byte_t      ob0_r, ob0_nxt;
  byte_t      ob1_r, ob1_nxt;
  logic [1:0] ocnt_r, ocnt_nxt;
  logic       olast_r, olast_nxt;

  // Room whenever the output register is empty or draining
  assign ev_ready = !ov_r || out_ready;

  // Up to two bytes wait until it is known whether more follow
  always_comb begin
    hold_cnt_nxt = hold_cnt_r;
    h0_nxt       = h0_r;
    h1_nxt       = h1_r;
    load         = 1'b0;
    ob0_nxt      = ob0_r;
    ob1_nxt      = ob1_r;
    ocnt_nxt     = ocnt_r;
    olast_nxt    = olast_r;
    if (ev.valid && ev_ready) begin
      if (ev.is_end) begin
        hold_cnt_nxt = 2'd0;
        ob0_nxt      = h0_r;
        ob1_nxt      = (hold_cnt_r == 2'd2) ? h1_r : BYTE_ZERO;
        ocnt_nxt     = hold_cnt_r;
        olast_nxt    = 1'b1;
        load         = (hold_cnt_r != 2'd0);
      end else if (hold_cnt_r == 2'd2) begin
        ob0_nxt      = h0_r;
        ob1_nxt      = h1_r;
        ocnt_nxt     = 2'd2;
        olast_nxt    = 1'b0;
        load         = 1'b1;
        h0_nxt       = ev.data;
        hold_cnt_nxt = 2'd1;
      end else if (hold_cnt_r == 2'd1) begin
        h1_nxt       = ev.data;
        hold_cnt_nxt = 2'd2;
      end else begin
        h0_nxt       = ev.data;
        hold_cnt_nxt = 2'd1;
      end
    end
    ov_nxt = load || (ov_r && !out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt_r <= 2'd0;
      ov_r       <= 1'b0;
    end else begin
      hold_cnt_r <= hold_cnt_nxt;
      ov_r       <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h0_r    <= h0_nxt;
    h1_r    <= h1_nxt;
    ob0_r   <= ob0_nxt;
    ob1_r   <= ob1_nxt;
    ocnt_r  <= ocnt_nxt;
    olast_r <= olast_nxt;
  end

  assign out_valid = ov_r;
  assign out_b0    = ob0_r;
  assign out_b1    = ob1_r;
  assign out_cnt   = ocnt_r;
  assign out_last  = olast_r;

endmodule

`default_nettype wire
